@@ hw/rtl/kgef_pkg.sv @@
// Shared types, codes and reset constants of the key gesture event machine.
`default_nettype none

package kgef_pkg;

   localparam int KEYS_W           = 16;
   localparam int TIME_W           = 32;
   localparam int CFG_W            = 16;
   localparam int CSR_INDEX_W      = 3;
   localparam int DEFAULT_NUM_KEYS = 16;
   localparam int EVQ_DEPTH        = 4;

   localparam logic [1:0] CLICK_MAX = 2'd3;

   localparam logic [CFG_W-1:0] RESET_COMBO_WINDOW    = 16'd50;
   localparam logic [CFG_W-1:0] RESET_HOLD_TIME       = 16'd1000;
   localparam logic [CFG_W-1:0] RESET_CLICK_GAP       = 16'd300;
   localparam logic [CFG_W-1:0] RESET_REPEAT_RATE     = 16'd100;
   localparam logic [CFG_W-1:0] RESET_MODIFIER_FILTER = 16'd300;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_COMBO_WINDOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_GAP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_RATE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODIFIER_FILTER = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_COMBO = 3'd1,
      ST_PRESS = 3'd2,
      ST_GAP   = 3'd3,
      ST_HOLD  = 3'd4
   } fsm_type;

   typedef enum logic [2:0] {
      EV_UP         = 3'd0,
      EV_HOLD_START = 3'd1,
      EV_CLICK      = 3'd2,
      EV_DOUBLE     = 3'd3,
      EV_TRIPLE     = 3'd4,
      EV_HOLD_END   = 3'd5,
      EV_MODIFIER   = 3'd6,
      EV_HOLDING    = 3'd7
   } kind_type;

   typedef struct packed {
      logic [CFG_W-1:0] combo_window;
      logic [CFG_W-1:0] hold_time;
      logic [CFG_W-1:0] click_gap;
      logic [CFG_W-1:0] repeat_rate;
      logic [CFG_W-1:0] modifier_filter;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] enter_time;
      logic [TIME_W-1:0] gap_start;
      logic [TIME_W-1:0] last_modifier;
      logic [TIME_W-1:0] last_repeat;
      logic [1:0]        click_count;
   } timer_type;

   typedef struct packed {
      logic [KEYS_W-1:0] keys;
      kind_type          kind;
      logic [TIME_W-1:0] param;
      logic [TIME_W-1:0] stamp;
      logic              last;
   } event_type;

endpackage

`default_nettype wire

@@ hw/rtl/kgef_step.sv @@
// Combinational step of the gesture machine: next state, timers and up to two events.
`default_nettype none

module kgef_step #(
   parameter int KEY_W = kgef_pkg::DEFAULT_NUM_KEYS
) (
   input  kgef_pkg::fsm_type          state,
   input  kgef_pkg::timer_type        timers,
   input  logic [KEY_W-1:0]           active_keys,
   input  kgef_pkg::cfg_type          cfg,
   input  logic [KEY_W-1:0]           pressed_keys,
   input  logic [kgef_pkg::TIME_W-1:0] now_ms,
   output kgef_pkg::fsm_type          state_next,
   output kgef_pkg::timer_type        timers_next,
   output logic [KEY_W-1:0]           active_keys_next,
   output kgef_pkg::event_type        event0,
   output kgef_pkg::event_type        event1,
   output logic [1:0]                 event_count
);
   import kgef_pkg::*;

   logic [TIME_W-1:0] since_enter;
   logic [TIME_W-1:0] since_gap;
   logic [TIME_W-1:0] since_mod;
   logic [TIME_W-1:0] since_rep;
   logic [TIME_W-1:0] hold_dur;
   logic              combo_to;
   logic              hold_to;
   logic              gap_to;
   logic              mod_to;
   logic              rep_to;
   logic [KEY_W-1:0]  combo_keys;
   logic [KEY_W-1:0]  extra_keys;
   logic              all_down;

   logic              ev_a_valid;
   logic              ev_b_valid;
   event_type         ev_a;
   event_type         ev_b;

   assign since_enter = now_ms - timers.enter_time;
   assign since_gap   = now_ms - timers.gap_start;
   assign since_mod   = now_ms - timers.last_modifier;
   assign since_rep   = now_ms - timers.last_repeat;
   assign hold_dur    = since_enter + TIME_W'(cfg.hold_time);

   assign combo_to = since_enter > TIME_W'(cfg.combo_window);
   assign hold_to  = since_enter > TIME_W'(cfg.hold_time);
   assign gap_to   = since_gap   > TIME_W'(cfg.click_gap);
   assign mod_to   = since_mod   > TIME_W'(cfg.modifier_filter);
   assign rep_to   = (cfg.repeat_rate != '0) && (since_rep > TIME_W'(cfg.repeat_rate));

   assign combo_keys = active_keys | pressed_keys;
   assign extra_keys = pressed_keys ^ active_keys;
   assign all_down   = (pressed_keys & active_keys) == active_keys;

   // Next state
   always_comb begin
      state_next = state;
      case (state)
         ST_COMBO: begin
            if (combo_to) begin
               state_next = (combo_keys != '0) ? ST_PRESS : ST_IDLE;
            end
         end
         ST_PRESS: begin
            if (pressed_keys == '0) begin
               state_next = ST_GAP;
            end else if (hold_to && all_down) begin
               state_next = ST_HOLD;
            end
         end
         ST_GAP: begin
            if (gap_to) begin
               state_next = ST_IDLE;
            end else if (pressed_keys != '0) begin
               state_next = (pressed_keys == active_keys) ? ST_PRESS : ST_COMBO;
            end
         end
         ST_HOLD: begin
            if (!all_down) begin
               state_next = ST_IDLE;
            end
         end
         default: begin
            state_next = (pressed_keys != '0) ? ST_COMBO : ST_IDLE;
         end
      endcase
   end

   // Timers, key set and raised events
   always_comb begin
      timers_next      = timers;
      active_keys_next = active_keys;
      ev_a_valid       = 1'b0;
      ev_b_valid       = 1'b0;
      ev_a             = '{keys: KEYS_W'(active_keys), kind: EV_UP, param: '0,
                           stamp: now_ms, last: 1'b0};
      ev_b             = ev_a;
      case (state)
         ST_COMBO: begin
            active_keys_next = combo_keys;
            if (combo_to && (combo_keys != '0)) begin
               timers_next.enter_time = now_ms;
            end
         end
         ST_PRESS: begin
            if (pressed_keys == '0) begin
               if (timers.click_count != CLICK_MAX) begin
                  timers_next.click_count = timers.click_count + 2'd1;
               end
               ev_a_valid            = 1'b1;
               ev_a.kind             = EV_UP;
               timers_next.gap_start = now_ms;
            end else if (hold_to && all_down) begin
               ev_a_valid              = 1'b1;
               ev_a.kind               = EV_HOLD_START;
               timers_next.enter_time  = now_ms;
               timers_next.click_count = '0;
            end
         end
         ST_GAP: begin
            if (gap_to) begin
               ev_a_valid = timers.click_count != 2'd0;
               case (timers.click_count)
                  2'd1:    ev_a.kind = EV_CLICK;
                  2'd2:    ev_a.kind = EV_DOUBLE;
                  default: ev_a.kind = EV_TRIPLE;
               endcase
               timers_next.click_count = '0;
            end else if (pressed_keys != '0) begin
               timers_next.enter_time = now_ms;
               if (pressed_keys != active_keys) begin
                  // another combination breaks the click run: settle as single
                  ev_a_valid              = 1'b1;
                  ev_a.kind               = EV_CLICK;
                  timers_next.click_count = '0;
                  active_keys_next        = pressed_keys;
               end
            end
         end
         ST_HOLD: begin
            if (!all_down) begin
               ev_a_valid = 1'b1;
               ev_a.kind  = EV_HOLD_END;
               ev_a.param = hold_dur;
               ev_b_valid = 1'b1;
               ev_b.kind  = EV_UP;
            end else begin
               if ((extra_keys != '0) && mod_to) begin
                  ev_a_valid                = 1'b1;
                  ev_a.kind                 = EV_MODIFIER;
                  ev_a.keys                 = KEYS_W'(active_keys | extra_keys);
                  timers_next.last_modifier = now_ms;
               end
               if (rep_to) begin
                  ev_b_valid              = 1'b1;
                  ev_b.kind               = EV_HOLDING;
                  ev_b.param              = hold_dur;
                  timers_next.last_repeat = now_ms;
               end
            end
         end
         default: begin
            if (pressed_keys != '0) begin
               active_keys_next        = pressed_keys;
               timers_next.enter_time  = now_ms;
               timers_next.click_count = '0;
            end
         end
      endcase
   end

   // Pack the raised events in order and mark the final one
   always_comb begin
      event0 = ev_a_valid ? ev_a : ev_b;
      event1 = ev_b;
      event0.last = !(ev_a_valid && ev_b_valid);
      event1.last = 1'b1;
      event_count = {1'b0, ev_a_valid} + {1'b0, ev_b_valid};
   end

endmodule

`default_nettype wire

@@ hw/rtl/key_gesture_event_fsm_unit.sv @@
// Top level of the key gesture event machine: tick register, state, event queue, CSRs.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   req     | in  | req_tvalid/tready    | tdata: pressed_keys[15:0], now_ms[47:16]
//   rsp     | out | rsp_tvalid/tready    | tdata: keys, param, time; tuser: kind; tlast
//   csr     | in  | csr_we (no wait)     | csr_index selects register, csr_wdata value
//
// A tick is taken into the tick register; from there the step logic updates the
// machine state and pushes zero, one or two events into a four-entry event queue.
// One tick per cycle is sustained while the queue has room for two events; each
// event needs one rsp transfer, so ticks raising two events are paced by the rsp
// side even under a ready sink. Synchronous active-high reset clears state, the
// queue and the registers to their defaults. A stalled rsp side holds the tick
// register once the queue lacks room for two events, which backs up req.
`default_nettype none

module key_gesture_event_fsm_unit #(
   parameter int NUM_KEYS = kgef_pkg::DEFAULT_NUM_KEYS
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: pressed_keys[15:0], now_ms[47:16]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata,
   // rsp_tdata: event_keys[15:0], event_param[47:16], event_time[79:48]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [79:0]                      rsp_tdata,
   // rsp_tuser: event_kind[2:0]
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [kgef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kgef_pkg::CFG_W-1:0]       csr_wdata
);
   import kgef_pkg::*;

   // keys above the event field width never reach the machine
   localparam int KEY_W   = (NUM_KEYS > KEYS_W) ? KEYS_W : NUM_KEYS;
   localparam int PTR_W   = $clog2(EVQ_DEPTH);
   localparam int COUNT_W = $clog2(EVQ_DEPTH + 1);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COMBO_WINDOW:    cfg_in.combo_window    = csr_wdata;
            CSR_HOLD_TIME:       cfg_in.hold_time       = csr_wdata;
            CSR_CLICK_GAP:       cfg_in.click_gap       = csr_wdata;
            CSR_REPEAT_RATE:     cfg_in.repeat_rate     = csr_wdata;
            CSR_MODIFIER_FILTER: cfg_in.modifier_filter = csr_wdata;
            default:             cfg_in = cfg_ff;  // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{combo_window:    RESET_COMBO_WINDOW,
                     hold_time:       RESET_HOLD_TIME,
                     click_gap:       RESET_CLICK_GAP,
                     repeat_rate:     RESET_REPEAT_RATE,
                     modifier_filter: RESET_MODIFIER_FILTER};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Tick register
   logic              tick_valid_ff, tick_valid_in;
   logic [KEY_W-1:0]  tick_mask_ff, tick_mask_in;
   logic [TIME_W-1:0] tick_now_ff, tick_now_in;
   logic [COUNT_W-1:0] evq_count_ff, evq_count_in;
   logic              step_fire;
   logic              req_xfer;

   // advance only when the queue can take the worst case of two events
   assign step_fire  = tick_valid_ff && (evq_count_ff <= COUNT_W'(EVQ_DEPTH - 2));
   assign req_tready = !tick_valid_ff || step_fire;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      tick_valid_in = tick_valid_ff;
      tick_mask_in  = tick_mask_ff;
      tick_now_in   = tick_now_ff;
      if (req_xfer) begin
         tick_valid_in = 1'b1;
         tick_mask_in  = req_tdata[KEY_W-1:0];
         tick_now_in   = req_tdata[KEYS_W +: TIME_W];
      end else if (step_fire) begin
         tick_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
      end
      tick_mask_ff <= tick_mask_in;
      tick_now_ff  <= tick_now_in;
   end

   // Machine state
   fsm_type          state_ff, state_in, state_next;
   timer_type        timers_ff, timers_in, timers_next;
   logic [KEY_W-1:0] active_ff, active_in, active_next;
   event_type        event0, event1;
   logic [1:0]       event_count;

   kgef_step #(
      .KEY_W(KEY_W)
   ) u_step (
      .state            (state_ff),
      .timers           (timers_ff),
      .active_keys      (active_ff),
      .cfg              (cfg_ff),
      .pressed_keys     (tick_mask_ff),
      .now_ms           (tick_now_ff),
      .state_next       (state_next),
      .timers_next      (timers_next),
      .active_keys_next (active_next),
      .event0           (event0),
      .event1           (event1),
      .event_count      (event_count)
   );

   // hold state unless a tick is processed
   always_comb begin
      state_in  = step_fire ? state_next  : state_ff;
      timers_in = step_fire ? timers_next : timers_ff;
      active_in = step_fire ? active_next : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         timers_ff <= '0;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         timers_ff <= timers_in;
         active_ff <= active_in;
      end
   end

   // Event queue
   event_type        evq_ff [EVQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0]       push_count;
   logic             rsp_xfer;
   event_type        head;

   assign push_count = step_fire ? event_count : 2'd0;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in    = rd_ptr_ff + PTR_W'(rsp_xfer);
      evq_count_in = evq_count_ff + COUNT_W'(push_count) - COUNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         evq_count_ff <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         evq_count_ff <= evq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         evq_ff[wr_ptr_ff] <= event0;
      end
      if (push_count == 2'd2) begin
         evq_ff[wr_ptr_ff + PTR_W'(1)] <= event1;
      end
   end

   assign head       = evq_ff[rd_ptr_ff];
   assign rsp_tvalid = evq_count_ff != '0;
   assign rsp_tdata  = {head.stamp, head.param, head.keys};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule

`default_nettype wire

@@ tb/sv/kgef_event_checker.sv @@
// Event predictor and scoreboard for the key gesture event machine.
`timescale 1ns / 100ps

module kgef_event_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [47:0]                      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [79:0]                      rsp_tdata,
   input  logic [2:0]                       rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [kgef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kgef_pkg::CFG_W-1:0]       csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import kgef_pkg::*;

   cfg_type           cfg;
   fsm_type           gesture_state;
   logic [TIME_W-1:0] enter_time;
   logic [TIME_W-1:0] gap_start;
   logic [TIME_W-1:0] last_modifier;
   logic [TIME_W-1:0] last_repeat;
   logic [KEYS_W-1:0] combo_keys;
   logic [1:0]        clicks;

   event_type         tick_events [2];
   int                tick_events_n;
   event_type         expected_events [$];
   int                errors = 0;

   function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] mark);
      return now - mark;
   endfunction

   task automatic raise(input logic [KEYS_W-1:0] keys, input kind_type kind,
                        input logic [TIME_W-1:0] param, input logic [TIME_W-1:0] stamp);
      event_type ev;
      ev.keys  = keys;
      ev.kind  = kind;
      ev.param = param;
      ev.stamp = stamp;
      ev.last  = 1'b0;
      tick_events[tick_events_n] = ev;
      tick_events_n++;
   endtask

   // Advance the gesture state by one scan tick and queue the events it raises.
   task automatic step_gesture(input logic [KEYS_W-1:0] mask, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] held_ms;
      logic [KEYS_W-1:0] extra;
      tick_events_n = 0;
      held_ms = now - enter_time + TIME_W'(cfg.hold_time);
      case (gesture_state)
         ST_COMBO: begin
            combo_keys = combo_keys | mask;
            if (since(now, enter_time) > cfg.combo_window) begin
               if (combo_keys != '0) begin
                  enter_time    = now;
                  gesture_state = ST_PRESS;
               end else begin
                  gesture_state = ST_IDLE;
               end
            end
         end
         ST_PRESS: begin
            if (mask == '0) begin
               if (clicks < CLICK_MAX) clicks++;
               raise(combo_keys, EV_UP, '0, now);
               gap_start     = now;
               gesture_state = ST_GAP;
            end else if (since(now, enter_time) > cfg.hold_time) begin
               // stay pressing while part of the combination is up
               if ((mask & combo_keys) == combo_keys) begin
                  raise(combo_keys, EV_HOLD_START, '0, now);
                  enter_time    = now;
                  clicks        = '0;
                  gesture_state = ST_HOLD;
               end
            end
         end
         ST_GAP: begin
            if (since(now, gap_start) > cfg.click_gap) begin
               if (clicks == 2'd1) raise(combo_keys, EV_CLICK, '0, now);
               else if (clicks == 2'd2) raise(combo_keys, EV_DOUBLE, '0, now);
               else if (clicks == CLICK_MAX) raise(combo_keys, EV_TRIPLE, '0, now);
               clicks        = '0;
               gesture_state = ST_IDLE;
            end else if (mask != '0) begin
               if (mask == combo_keys) begin
                  enter_time    = now;
                  gesture_state = ST_PRESS;
               end else begin
                  // a new combination ends the old one as a single click
                  raise(combo_keys, EV_CLICK, '0, now);
                  clicks        = '0;
                  combo_keys    = mask;
                  enter_time    = now;
                  gesture_state = ST_COMBO;
               end
            end
         end
         ST_HOLD: begin
            if ((mask & combo_keys) != combo_keys) begin
               raise(combo_keys, EV_HOLD_END, held_ms, now);
               raise(combo_keys, EV_UP, '0, now);
               gesture_state = ST_IDLE;
            end else begin
               extra = mask ^ combo_keys;
               if (extra != '0 && since(now, last_modifier) > cfg.modifier_filter) begin
                  raise(combo_keys | extra, EV_MODIFIER, '0, now);
                  last_modifier = now;
               end
               if (cfg.repeat_rate != '0 && since(now, last_repeat) > cfg.repeat_rate) begin
                  raise(combo_keys, EV_HOLDING, held_ms, now);
                  last_repeat = now;
               end
            end
         end
         default: begin
            if (mask != '0) begin
               combo_keys    = mask;
               enter_time    = now;
               clicks        = '0;
               gesture_state = ST_COMBO;
            end else begin
               gesture_state = ST_IDLE;
            end
         end
      endcase
      if (tick_events_n > 0) tick_events[tick_events_n - 1].last = 1'b1;
      for (int i = 0; i < tick_events_n; i++) expected_events.push_back(tick_events[i]);
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, seen);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      event_type want;
      if (reset) begin
         cfg.combo_window    = RESET_COMBO_WINDOW;
         cfg.hold_time       = RESET_HOLD_TIME;
         cfg.click_gap       = RESET_CLICK_GAP;
         cfg.repeat_rate     = RESET_REPEAT_RATE;
         cfg.modifier_filter = RESET_MODIFIER_FILTER;
         gesture_state       = ST_IDLE;
         enter_time          = '0;
         gap_start           = '0;
         last_modifier       = '0;
         last_repeat         = '0;
         combo_keys          = '0;
         clicks              = '0;
         expected_events.delete();
      end else begin
         // compare first: a tick taken at this edge has no event out yet
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event: keys %h kind %0d time %h",
                      rsp_tdata[15:0], rsp_tuser, rsp_tdata[79:48]);
               errors++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_keys", want.keys, rsp_tdata[15:0]);
               check_field("event_kind", want.kind, rsp_tuser);
               check_field("event_param", want.param, rsp_tdata[47:16]);
               check_field("event_time", want.stamp, rsp_tdata[79:48]);
               check_field("last_event", want.last, rsp_tlast);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_COMBO_WINDOW:    cfg.combo_window    = csr_wdata;
               CSR_HOLD_TIME:       cfg.hold_time       = csr_wdata;
               CSR_CLICK_GAP:       cfg.click_gap       = csr_wdata;
               CSR_REPEAT_RATE:     cfg.repeat_rate     = csr_wdata;
               CSR_MODIFIER_FILTER: cfg.modifier_filter = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) step_gesture(req_tdata[15:0], req_tdata[47:16]);
      end
      pending    <= expected_events.size();
      fail_count <= errors;
   end

endmodule

@@ tb/sv/key_gesture_event_fsm_unit_test.sv @@
// Testbench top for the key gesture event machine: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module key_gesture_event_fsm_unit_test;
   import kgef_pkg::*;

   localparam int                RANDOM_ITEMS  = 850;
   localparam int                NUM_PHASES    = 7;
   // tick register, step logic and event queue, with margin
   localparam int                SETTLE_CYCLES = 8;
   // start just below the wrap of the millisecond counter
   localparam logic [TIME_W-1:0] DIRECTED_BASE = 32'hFFFF_F900;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST = CSR_MODIFIER_FILTER;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [79:0]            rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_COMBO_WINDOW;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   int                     fail_count;
   int                     pending;

   // stimulus side copy of the registers, used only to scale time steps
   cfg_type                cfg_now;
   logic [TIME_W-1:0]      tick_time;
   int                     items_sent    = 0;
   int                     directed_n    = 0;
   int                     send_idle_pct = 23;
   int                     recv_idle_pct = 73;

   key_gesture_event_fsm_unit DUT (.*);

   kgef_event_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the event side at random; the rate follows the stimulus stage.
   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // Hard stop in case a transfer never completes.
   initial begin
      #400_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Present one scan tick, step time forward, and hold it until the transfer.
   task automatic send_tick(input logic [KEYS_W-1:0] mask, input logic [TIME_W-1:0] step);
      tick_time = tick_time + step;
      // receiver idles first, then the sender, then neither
      if (items_sent < RANDOM_ITEMS / 3) begin
         send_idle_pct = 23;
         recv_idle_pct = 73;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 73;
         recv_idle_pct = 23;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tick_time, mask};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_at(input logic [KEYS_W-1:0] mask, input logic [TIME_W-1:0] offset);
      send_tick(mask, DIRECTED_BASE + offset - tick_time);
   endtask

   // Drop valid and wait until every event is out and the pipe is quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_COMBO_WINDOW;
      csr_wdata <= c.combo_window;
      @(posedge clock);
      csr_index <= CSR_HOLD_TIME;
      csr_wdata <= c.hold_time;
      @(posedge clock);
      csr_index <= CSR_CLICK_GAP;
      csr_wdata <= c.click_gap;
      @(posedge clock);
      csr_index <= CSR_REPEAT_RATE;
      csr_wdata <= c.repeat_rate;
      @(posedge clock);
      csr_index <= CSR_MODIFIER_FILTER;
      csr_wdata <= c.modifier_filter;
      @(posedge clock);
      // an index past the last register must leave everything alone
      csr_index <= CSR_INDEX_LAST + CSR_INDEX_W'($urandom_range(1, 3));
      csr_wdata <= CFG_W'($urandom());
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_now = c;
   endtask

   function automatic logic [CFG_W-1:0] pick_span();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CFG_W'($urandom_range(1, 400));
      endcase
   endfunction

   function automatic cfg_type pick_config(input int phase);
      cfg_type c;
      if (phase == 0) begin
         c = '0;
      end else if (phase == 1) begin
         c = '1;
      end else if (phase == NUM_PHASES - 1) begin
         c.combo_window    = RESET_COMBO_WINDOW;
         c.hold_time       = RESET_HOLD_TIME;
         c.click_gap       = RESET_CLICK_GAP;
         c.repeat_rate     = RESET_REPEAT_RATE;
         c.modifier_filter = RESET_MODIFIER_FILTER;
      end else begin
         c.combo_window    = pick_span();
         c.hold_time       = pick_span();
         c.click_gap       = pick_span();
         c.repeat_rate     = pick_span();
         c.modifier_filter = pick_span();
      end
      return c;
   endfunction

   // A step that stays well inside a window.
   function automatic logic [TIME_W-1:0] short_step(input int unsigned span);
      return $urandom_range(0, span / 4 + 1);
   endfunction

   // A step that lands on a window's limit, just past it, or well past it.
   function automatic logic [TIME_W-1:0] limit_step(input int unsigned span);
      case ($urandom_range(0, 3))
         0:       return span;
         1:       return span + 1;
         2:       return span + $urandom_range(2, 20);
         default: return span + $urandom_range(0, span + 1);
      endcase
   endfunction

   function automatic logic [KEYS_W-1:0] pick_keys();
      case ($urandom_range(0, 5))
         0:       return 16'h0001 << $urandom_range(0, 15);
         1:       return '1;
         2:       return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
         default: return KEYS_W'($urandom_range(1, 16'hFFFF));
      endcase
   endfunction

   // One well-formed gesture with random content, or a burst of noise.
   task automatic play_gesture();
      logic [KEYS_W-1:0] keys;
      logic [KEYS_W-1:0] mask;
      logic [KEYS_W-1:0] extra;
      int unsigned       presses;
      int unsigned       span;
      int unsigned       i;
      keys = pick_keys();
      // gather the combination: part of it first, the rest inside the window
      mask = keys & KEYS_W'($urandom());
      send_tick((mask == '0) ? keys : mask, short_step(cfg_now.click_gap));
      repeat ($urandom_range(0, 2)) send_tick(keys, short_step(cfg_now.combo_window));
      send_tick(keys, limit_step(cfg_now.combo_window));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            presses = $urandom_range(1, 4);
            for (i = 0; i < presses; i++) begin
               if (i != 0) send_tick(keys, short_step(cfg_now.click_gap));
               repeat ($urandom_range(0, 1)) send_tick(keys, short_step(cfg_now.hold_time));
               send_tick('0, short_step(cfg_now.hold_time));
            end
            // settle the count, or break the gap with another combination
            if ($urandom_range(0, 3) == 0) begin
               send_tick(keys ^ KEYS_W'($urandom_range(1, 16'hFFFF)),
                         short_step(cfg_now.click_gap));
            end else begin
               send_tick('0, limit_step(cfg_now.click_gap));
               send_tick('0, 1 + short_step(cfg_now.click_gap));
            end
         end
         5, 6, 7, 8: begin
            // reach the hold time, now and then with part of the combination up
            mask = ($urandom_range(0, 3) == 0) ? (keys & KEYS_W'($urandom())) : keys;
            send_tick((mask == '0) ? keys : mask, limit_step(cfg_now.hold_time));
            send_tick(keys, 1 + short_step(cfg_now.hold_time));
            repeat ($urandom_range(1, 6)) begin
               extra = ($urandom_range(0, 2) == 0) ? KEYS_W'($urandom()) : '0;
               span  = $urandom_range(0, 1) ? cfg_now.repeat_rate : cfg_now.modifier_filter;
               send_tick(keys | extra,
                         $urandom_range(0, 1) ? limit_step(span) : short_step(span));
            end
            // let go of at least one key of the combination
            mask = keys & KEYS_W'($urandom());
            if (mask == keys) mask = '0;
            send_tick(mask | (~keys & KEYS_W'($urandom())), short_step(cfg_now.repeat_rate));
         end
         default: begin
            repeat ($urandom_range(1, 4)) begin
               send_tick(KEYS_W'($urandom()),
                         $urandom_range(0, 1) ? $urandom() : short_step(cfg_now.click_gap));
            end
         end
      endcase
   endtask

   initial begin
      cfg_now.combo_window    = RESET_COMBO_WINDOW;
      cfg_now.hold_time       = RESET_HOLD_TIME;
      cfg_now.click_gap       = RESET_CLICK_GAP;
      cfg_now.repeat_rate     = RESET_REPEAT_RATE;
      cfg_now.modifier_filter = RESET_MODIFIER_FILTER;
      tick_time               = DIRECTED_BASE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset register values, across the time wrap.
      send_at(16'h0000, 0);      // idle with nothing down
      send_at(16'h0001, 10);     // open a combination
      send_at(16'h0001, 60);     // exactly the window: keep gathering
      send_at(16'h0001, 61);     // past the window: pressing
      send_at(16'h0000, 80);     // up, first click
      send_at(16'h0001, 100);
      send_at(16'h0000, 110);    // up, second click
      send_at(16'h0001, 120);
      send_at(16'h0000, 130);    // up, third click
      send_at(16'h0001, 140);
      send_at(16'h0000, 150);    // up, count saturates
      send_at(16'h0000, 450);    // exactly the gap: no settle yet
      send_at(16'h0000, 451);    // triple click
      send_at(16'h8001, 500);
      send_at(16'h8001, 551);    // pressing
      send_at(16'h0001, 1552);   // hold time passed with the combination broken
      send_at(16'h8001, 1560);   // hold start
      send_at(16'h8101, 1570);   // modifier click and holding on the first hold tick
      send_at(16'hFFFF, 1600);   // both timers still running
      send_at(16'h8001, 1671);   // holding again
      send_at(16'h8000, 1700);   // hold end and up just before the time wrap
      send_at(16'h0002, 1710);
      send_at(16'h0002, 1800);   // pressing, window measured across the time wrap
      send_at(16'h0000, 1810);   // up
      send_at(16'h0004, 1820);   // other keys in the gap: single click, new combination
      send_at(16'h0000, 1900);   // pressing on gathered keys
      send_at(16'h0000, 1910);   // up
      send_at(16'h0000, 2300);   // single click
      directed_n = items_sent;

      // Random gestures over a run of register settings, extremes first.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         load_config(pick_config(phase));
         while (items_sent < directed_n + (phase + 1) * RANDOM_ITEMS / NUM_PHASES)
            play_gesture();
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
